>>> rtl/sorted_priority_queue_defines.svh
// ------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared property forms for the port-level checker
// ------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

>>> rtl/spq_pkg.sv
// ------------------------------------------------------------------------
// spq_pkg
// shared constants and types of the sorted priority queue
// ------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FILL_W   = 5;
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		OPC_ENQ = 1'b0,
		OPC_DEQ = 1'b1
	} opcode_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_INSERT,
		DP_REMOVE,
		DP_REJECT_FULL,
		DP_REJECT_EMPTY
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic op_dequeue;
		logic empty;
		logic full;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/spq_ctrl.sv
// ------------------------------------------------------------------------
// spq_ctrl
// sequencer: takes a command, picks the datapath operation, strobes done
// ------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire spq_pkg::dp_stat_t stat,
	output spq_pkg::dp_cmd_t       cmd,
	output logic                   busy,
	output logic                   done
);

	spq_pkg::state_t state_q, state_d;
	logic            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == spq_pkg::ST_EXEC);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				if (start) state_d = spq_pkg::ST_EXEC;
			end
			spq_pkg::ST_EXEC: begin
				state_d = spq_pkg::ST_IDLE;
			end
			default: begin
				state_d = spq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.op = spq_pkg::DP_NOP;
		busy   = 1'b0;
		case (state_q)
			spq_pkg::ST_IDLE: begin
				if (start) cmd.op = spq_pkg::DP_LOAD;
			end
			spq_pkg::ST_EXEC: begin
				busy = 1'b1;
				if (stat.op_dequeue) begin
					cmd.op = stat.empty ? spq_pkg::DP_REJECT_EMPTY : spq_pkg::DP_REMOVE;
				end else begin
					cmd.op = stat.full ? spq_pkg::DP_REJECT_FULL : spq_pkg::DP_INSERT;
				end
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign done = done_q;

endmodule

`default_nettype wire

>>> rtl/spq_datapath.sv
// ------------------------------------------------------------------------
// spq_datapath
// row of sorted cells with parallel compare, insert shift and pop shift
// ------------------------------------------------------------------------
`default_nettype none

module spq_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire spq_pkg::dp_cmd_t                    cmd,
	input  wire logic                                operation,
	input  wire logic signed [spq_pkg::DATA_W-1:0]   item_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0]   item_priority,
	output spq_pkg::dp_stat_t                        stat,
	output logic [1:0]                               status,
	output logic signed [spq_pkg::DATA_W-1:0]        out_value,
	output logic [spq_pkg::FILL_W-1:0]               fill_count
);

	localparam int CAP = spq_pkg::CAPACITY;

	// latched command operands
	logic                              op_q;
	logic signed [spq_pkg::DATA_W-1:0] val_q;
	logic signed [spq_pkg::DATA_W-1:0] pri_q;

	// cell row, entries at and above the count hold stale data
	logic signed [spq_pkg::DATA_W-1:0] cell_val_q [CAP];
	logic signed [spq_pkg::DATA_W-1:0] cell_pri_q [CAP];
	logic signed [spq_pkg::DATA_W-1:0] cell_val_d [CAP];
	logic signed [spq_pkg::DATA_W-1:0] cell_pri_d [CAP];
	logic [spq_pkg::CNT_W-1:0]         count_q;
	logic [spq_pkg::CNT_W-1:0]         count_d;

	spq_pkg::status_t                  status_q;
	logic signed [spq_pkg::DATA_W-1:0] out_value_q;
	logic [spq_pkg::FILL_W-1:0]        fill_q;

	// cell holds a priority >= the new one, empty cells count as such
	logic [CAP-1:0] ge;

	always_ff @(posedge clk) begin
		if (cmd.op == spq_pkg::DP_LOAD) begin
			op_q  <= operation;
			val_q <= item_value;
			pri_q <= item_priority;
		end
	end

	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			ge[i] = (spq_pkg::CNT_W'(i) >= count_q) || (cell_pri_q[i] >= pri_q);
		end
	end

	always_comb begin
		count_d = count_q;
		for (int i = 0; i < CAP; i++) begin
			cell_val_d[i] = cell_val_q[i];
			cell_pri_d[i] = cell_pri_q[i];
		end
		case (cmd.op)
			spq_pkg::DP_INSERT: begin
				count_d = count_q + spq_pkg::CNT_W'(1);
				for (int i = 0; i < CAP; i++) begin
					if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
						cell_val_d[i] = cell_val_q[(i > 0) ? i - 1 : 0];
						cell_pri_d[i] = cell_pri_q[(i > 0) ? i - 1 : 0];
					end else if (ge[i]) begin
						cell_val_d[i] = val_q;
						cell_pri_d[i] = pri_q;
					end
				end
			end
			spq_pkg::DP_REMOVE: begin
				count_d = count_q - spq_pkg::CNT_W'(1);
				for (int i = 0; i < CAP - 1; i++) begin
					cell_val_d[i] = cell_val_q[i + 1];
					cell_pri_d[i] = cell_pri_q[i + 1];
				end
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAP; i++) begin
			cell_val_q[i] <= cell_val_d[i];
			cell_pri_q[i] <= cell_pri_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// result registers, loaded in the execute cycle
	always_ff @(posedge clk) begin
		case (cmd.op)
			spq_pkg::DP_INSERT: begin
				status_q    <= spq_pkg::STAT_OK;
				out_value_q <= '0;
				fill_q      <= spq_pkg::FILL_W'(count_d);
			end
			spq_pkg::DP_REMOVE: begin
				status_q    <= spq_pkg::STAT_OK;
				out_value_q <= cell_val_q[0];
				fill_q      <= spq_pkg::FILL_W'(count_d);
			end
			spq_pkg::DP_REJECT_FULL: begin
				status_q    <= spq_pkg::STAT_FULL;
				out_value_q <= '0;
				fill_q      <= spq_pkg::FILL_W'(count_q);
			end
			spq_pkg::DP_REJECT_EMPTY: begin
				status_q    <= spq_pkg::STAT_EMPTY;
				out_value_q <= '0;
				fill_q      <= spq_pkg::FILL_W'(count_q);
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign stat.op_dequeue = (op_q == spq_pkg::OPC_DEQ);
	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q >= spq_pkg::CNT_W'(CAP));

	assign status     = status_q;
	assign out_value  = out_value_q;
	assign fill_count = fill_q;

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// ------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue, smallest priority number leaves first
// ------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start / busy       operation, item_value, item_priority
//  result    done (one cycle)   status, out_value, fill_count
//
// a command is taken when start is high and busy is low; busy is high for
// the one execute cycle in which all cells compare and shift in parallel
// done pulses the cycle after; no new command is taken while busy is high
// arst_n empties the queue; cell contents are not cleared
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module sorted_priority_queue (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                operation,
	input  wire logic signed [spq_pkg::DATA_W-1:0]   item_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0]   item_priority,
	output logic                                     done,
	output logic [1:0]                               status,
	output logic signed [spq_pkg::DATA_W-1:0]        out_value,
	output logic [spq_pkg::FILL_W-1:0]               fill_count
);

	spq_pkg::dp_cmd_t  cmd;
	spq_pkg::dp_stat_t stat;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	spq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (operation),
		.item_value    (item_value),
		.item_priority (item_priority),
		.stat          (stat),
		.status        (status),
		.out_value     (out_value),
		.fill_count    (fill_count)
	);

endmodule

`default_nettype wire

>>> rtl/spq_checker.sv
// ------------------------------------------------------------------------
// spq_checker
// port-level checks on command and result timing and result codes
// ------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_defines.svh"

module spq_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic                              done,
	input wire logic [1:0]                        status,
	input wire logic [spq_pkg::DATA_W-1:0]        out_value,
	input wire logic [spq_pkg::FILL_W-1:0]        fill_count
);

	// an accepted command goes to execute on the next cycle
	`SPQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// every execute cycle produces exactly one result strobe
	`SPQ_ASSERT_NEXT(a_busy_done, clk, arst_n, busy, done && !busy)

	// a full rejection reports the queue at capacity
	`SPQ_ASSERT_NOW(a_full_count, clk, arst_n, done && status == spq_pkg::STAT_FULL,
		fill_count == spq_pkg::FILL_W'(spq_pkg::CAPACITY) && out_value == '0)

	// an empty dequeue reports nothing stored
	`SPQ_ASSERT_NOW(a_empty_zero, clk, arst_n, done && status == spq_pkg::STAT_EMPTY,
		fill_count == '0 && out_value == '0)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

>>> bench/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// sorted_priority_queue_tb
// a stimulus table of extremes and special cases, then random bursts that
// swing the fill level between empty and full; results are checked against
// typed rows or a sorted-list predictor in step with each command transfer
// ------------------------------------------------------------------------

module sorted_priority_queue_tb;

	localparam int RANDOM_ITEMS = 1700;
	localparam int MAX_GAP      = 13;
	localparam int BURST_LEN    = 40;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_LIMIT = 10;
	localparam int TABLE_ROWS   = 25;

	// short names for the stimulus table
	localparam spq_pkg::opcode_t ENQ     = spq_pkg::OPC_ENQ;
	localparam spq_pkg::opcode_t DEQ     = spq_pkg::OPC_DEQ;
	localparam spq_pkg::status_t S_OK    = spq_pkg::STAT_OK;
	localparam spq_pkg::status_t S_EMPTY = spq_pkg::STAT_EMPTY;
	localparam spq_pkg::status_t S_FULL  = spq_pkg::STAT_FULL;

	typedef struct packed {
		spq_pkg::status_t                   status;
		logic signed [spq_pkg::DATA_W-1:0]  value;
		logic [spq_pkg::FILL_W-1:0]         fill;
	} result_t;

	typedef struct packed {
		spq_pkg::opcode_t                   op;
		logic signed [spq_pkg::DATA_W-1:0]  value;
		logic signed [spq_pkg::DATA_W-1:0]  prio;
		logic                               typed;
		result_t                            want;
	} stim_row_t;

	logic                               clk           = 1'b0;
	logic                               arst_n        = 1'b0;
	logic                               start         = 1'b0;
	logic                               operation     = spq_pkg::OPC_ENQ;
	logic signed [spq_pkg::DATA_W-1:0]  item_value    = '0;
	logic signed [spq_pkg::DATA_W-1:0]  item_priority = '0;
	logic                               busy;
	logic                               done;
	logic [1:0]                         status;
	logic signed [spq_pkg::DATA_W-1:0]  out_value;
	logic [spq_pkg::FILL_W-1:0]         fill_count;

	// predictor copy of the queue, head at index 0
	logic signed [spq_pkg::DATA_W-1:0]  queue_vals [spq_pkg::CAPACITY];
	logic signed [spq_pkg::DATA_W-1:0]  queue_pris [spq_pkg::CAPACITY];
	int                                 queue_len = 0;

	result_t                    pending_results [$];
	int                         fail_count  = 0;
	int                         cycle_count = 0;

	// typed rows: after reset, extremes and error codes
	stim_row_t directed_rows [TABLE_ROWS] = '{
		'{DEQ, 32'sd0,         32'sd0,         1'b1, '{S_EMPTY, 32'sd0, 5'd0}},
		'{ENQ, 32'h7fffffff,   32'h7fffffff,   1'b1, '{S_OK, 32'sd0, 5'd1}},
		'{ENQ, 32'h80000000,   32'h80000000,   1'b1, '{S_OK, 32'sd0, 5'd2}},
		'{DEQ, 32'hffffffff,   32'hffffffff,   1'b1, '{S_OK, 32'h80000000, 5'd1}},
		'{DEQ, 32'sd0,         32'sd0,         1'b1, '{S_OK, 32'h7fffffff, 5'd0}},
		'{DEQ, 32'h5a5a5a5a,   32'ha5a5a5a5,   1'b1, '{S_EMPTY, 32'sd0, 5'd0}},
		// equal priorities leave newest first
		'{ENQ, 32'sd1,         32'sd5,         1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'sd2,         32'sd5,         1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'sd3,         32'sd5,         1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'sd4,         -32'sd1,        1'b0, '{S_OK, 32'sd0, 5'd0}},
		// fill to capacity
		'{ENQ, 32'h12345678,   32'sd3,         1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'h87654321,   -32'sd7,        1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'hdeadbeef,   32'sd100,       1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'hcafef00d,   32'sd5,         1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'h00000000,   32'sd0,         1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'hffffffff,   32'h80000000,   1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'h80000000,   32'h7fffffff,   1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'h7fffffff,   32'sd42,        1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'h0f0f0f0f,   -32'sd1,        1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'hf0f0f0f0,   32'sd5,         1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'h33333333,   32'sd9,         1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'hcccccccc,   32'sd3,         1'b0, '{S_OK, 32'sd0, 5'd0}},
		'{ENQ, 32'h11111111,   32'sd1,         1'b1, '{S_FULL, 32'sd0, 5'd16}},
		'{ENQ, 32'h22222222,   32'h80000000,   1'b1, '{S_FULL, 32'sd0, 5'd16}},
		'{DEQ, 32'sd0,         32'sd0,         1'b0, '{S_OK, 32'sd0, 5'd0}}
	};

	sorted_priority_queue uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.item_value    (item_value),
		.item_priority (item_priority),
		.done          (done),
		.status        (status),
		.out_value     (out_value),
		.fill_count    (fill_count)
	);

	always #4 clk = ~clk;

	function automatic result_t predict_queue_op(spq_pkg::opcode_t op,
			logic signed [spq_pkg::DATA_W-1:0] val, logic signed [spq_pkg::DATA_W-1:0] pri);
		result_t r;
		int      pos;
		r = '{spq_pkg::STAT_OK, '0, '0};
		if (op == spq_pkg::OPC_ENQ) begin
			if (queue_len >= spq_pkg::CAPACITY) begin
				r.status = spq_pkg::STAT_FULL;
			end else begin
				// in front of the first entry with priority >= the new one
				pos = queue_len;
				for (int i = queue_len - 1; i >= 0; i--) begin
					if (queue_pris[i] >= pri)
						pos = i;
				end
				for (int i = queue_len; i > pos; i--) begin
					queue_vals[i] = queue_vals[i-1];
					queue_pris[i] = queue_pris[i-1];
				end
				queue_vals[pos] = val;
				queue_pris[pos] = pri;
				queue_len++;
			end
		end else if (queue_len == 0) begin
			r.status = spq_pkg::STAT_EMPTY;
		end else begin
			r.value = queue_vals[0];
			for (int i = 1; i < queue_len; i++) begin
				queue_vals[i-1] = queue_vals[i];
				queue_pris[i-1] = queue_pris[i];
			end
			queue_len--;
		end
		r.fill = spq_pkg::FILL_W'(queue_len);
		return r;
	endfunction

	// one command transfer; returns at the edge that takes it
	task automatic send_command(spq_pkg::opcode_t op, logic signed [spq_pkg::DATA_W-1:0] val,
			logic signed [spq_pkg::DATA_W-1:0] pri, int gap, logic typed, result_t want);
		result_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		operation     <= op;
		item_value    <= val;
		item_priority <= pri;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = predict_queue_op(op, val, pri);
		pending_results.push_back(typed ? want : predicted);
	endtask

	initial begin : stimulus
		int                                 enq_pct;
		int                                 prio_mode;
		logic                               no_idle;
		spq_pkg::opcode_t                   op_sel;
		logic signed [spq_pkg::DATA_W-1:0]  pri;
		enq_pct   = 50;
		prio_mode = 0;
		no_idle   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < TABLE_ROWS; row++)
			send_command(directed_rows[row].op, directed_rows[row].value,
				directed_rows[row].prio, $urandom_range(0, MAX_GAP),
				directed_rows[row].typed, directed_rows[row].want);

		for (int item = 0; item < RANDOM_ITEMS; item++) begin
			// bursts lean toward filling, draining or holding level
			if (item % BURST_LEN == 0) begin
				case ($urandom_range(0, 2))
					0: enq_pct = 85;
					1: enq_pct = 50;
					default: enq_pct = 15;
				endcase
				prio_mode = $urandom_range(0, 2);
				no_idle   = ($urandom_range(0, 3) == 0);
			end
			op_sel = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::OPC_ENQ : spq_pkg::OPC_DEQ;
			case (prio_mode)
				0: pri = $urandom;
				// narrow range, lots of ties
				1: pri = $signed($urandom_range(0, 7)) - 4;
				default: begin
					case ($urandom_range(0, 4))
						0: pri = 32'h80000000;
						1: pri = 32'h7fffffff;
						2: pri = 32'sd0;
						3: pri = -32'sd1;
						default: pri = $urandom;
					endcase
				end
			endcase
			send_command(op_sel, $urandom, pri, no_idle ? 0 : $urandom_range(0, MAX_GAP),
				1'b0, '0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("result with nothing pending: status %0d value %0d fill %0d",
						status, out_value, fill_count);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || out_value !== want.value ||
						fill_count !== want.fill) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("mismatch: status %0d/%0d value %0d/%0d fill %0d/%0d (exp/got)",
							want.status, status, want.value, out_value, want.fill, fill_count);
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule
